// ===== src/grbt_pkg.sv =====
// ----------------------------------------------------------------------------
// grbt_pkg
// Shared types and constants for the general register rename buffer table.
// ----------------------------------------------------------------------------
`default_nettype none

package grbt_pkg;

  // Default sizes of the map and the buffer pool
  localparam int unsigned NUM_REGS_DEF    = 32;
  localparam int unsigned NUM_BUFFERS_DEF = 8;

  // Port field widths
  localparam int unsigned CMD_W = 3;
  localparam int unsigned REG_W = 5;
  localparam int unsigned TAG_W = 3;
  localparam int unsigned CNT_W = 4;

  // Command codes; unused codes behave as a query
  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY   = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_FREE_IO = 3'd2,
    CMD_FREE_RV = 3'd3,
    CMD_MARK    = 3'd4
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;    // capture the input word
    logic alloc_rd;    // read the map entry of the register
    logic alloc_wr;    // write the new buffer and repoint the map
    logic alloc_link;  // link the previous newest buffer to the new one
    logic free_rd;     // read the links of the buffer being freed
    logic free_wr;     // unlink the buffer and release it
    logic mark_rdy;    // set the ready mark of the buffer
    logic rep_rd;      // read the map and buffer entries for the result
    logic rep_ld;      // load the result register
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_e cmd;       // latched command
    logic alloc_go;  // register in range and a buffer is free
    logic free_go;   // tag in range and the buffer is busy
    logic out_free;  // result register can take a new word
  } status_t;

endpackage

`default_nettype wire

// ===== src/grbt_ram.sv =====
// ----------------------------------------------------------------------------
// grbt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module grbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/grbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// grbt_ctrl
// Sequencer: steps one command word through its read and write cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module grbt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire grbt_pkg::status_t sts_i,
  output grbt_pkg::ctrl_t       ctl_o
);

  import grbt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ALLOC_WR,
    ST_ALLOC_LINK,
    ST_FREE_WR,
    ST_REP_RD,
    ST_REP_LD
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch_in = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.cmd) inside
          CMD_ALLOC: begin
            if (sts_i.alloc_go) begin
              ctl_o.alloc_rd = 1'b1;
              state_d        = ST_ALLOC_WR;
            end else begin
              state_d = ST_REP_RD;
            end
          end
          CMD_FREE_IO, CMD_FREE_RV: begin
            if (sts_i.free_go) begin
              ctl_o.free_rd = 1'b1;
              state_d       = ST_FREE_WR;
            end else begin
              state_d = ST_REP_RD;
            end
          end
          CMD_MARK: begin
            ctl_o.mark_rdy = 1'b1;
            state_d        = ST_REP_RD;
          end
          default: begin
            state_d = ST_REP_RD;
          end
        endcase
      end
      ST_ALLOC_WR: begin
        ctl_o.alloc_wr = 1'b1;
        state_d        = ST_ALLOC_LINK;
      end
      ST_ALLOC_LINK: begin
        ctl_o.alloc_link = 1'b1;
        state_d          = ST_REP_RD;
      end
      ST_FREE_WR: begin
        ctl_o.free_wr = 1'b1;
        state_d       = ST_REP_RD;
      end
      ST_REP_RD: begin
        ctl_o.rep_rd = 1'b1;
        state_d      = ST_REP_LD;
      end
      ST_REP_LD: begin
        // wait here while the previous word still sits unread
        if (sts_i.out_free) begin
          ctl_o.rep_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== src/grbt_dp.sv =====
// ----------------------------------------------------------------------------
// grbt_dp
// Datapath: map table, buffer link tables, busy/ready marks, free counter
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module grbt_dp #(
  parameter int unsigned NUM_REGS    = grbt_pkg::NUM_REGS_DEF,
  parameter int unsigned NUM_BUFFERS = grbt_pkg::NUM_BUFFERS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire grbt_pkg::ctrl_t             ctl_i,
  output grbt_pkg::status_t                sts_o,
  input  wire logic [grbt_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [grbt_pkg::REG_W-1:0]  reg_num_i,
  input  wire logic [grbt_pkg::TAG_W-1:0]  tag_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             alloc_ok_o,
  output logic      [grbt_pkg::TAG_W-1:0]  alloc_tag_o,
  output logic                             map_present_o,
  output logic      [grbt_pkg::TAG_W-1:0]  map_tag_o,
  output logic                             buffer_busy_o,
  output logic      [grbt_pkg::REG_W-1:0]  buffer_reg_o,
  output logic                             buffer_ready_o,
  output logic      [grbt_pkg::CNT_W-1:0]  free_count_o
);

  import grbt_pkg::*;

  localparam int unsigned RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned TW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned CW = $clog2(NUM_BUFFERS + 1);

  // Latched input word
  logic [CMD_W-1:0] cmd_q;
  logic [REG_W-1:0] reg_q;
  logic [TAG_W-1:0] tag_q;
  logic [RW-1:0]    ridx;
  logic [TW-1:0]    tidx;
  logic             reg_ok;
  logic             tag_ok;

  // Per-buffer and per-register marks
  logic [NUM_BUFFERS-1:0] busy_q;
  logic [NUM_BUFFERS-1:0] ready_q;
  logic [NUM_REGS-1:0]    present_q;
  logic [CW-1:0]          cnt_q;

  // Allocation bookkeeping
  logic [TW-1:0] free_idx;
  logic [TW-1:0] alloc_t_q;
  logic          alloc_ok_q;
  logic          alloc_prev_q;

  // RAM ports
  logic          map_we,  prev_we,  next_we,  reg_we;
  logic [RW-1:0] map_waddr, reg_wdata;
  logic [TW-1:0] map_wdata, prev_waddr, next_waddr, reg_waddr;
  logic [TW:0]   prev_wdata, next_wdata;
  logic [TW-1:0] map_rdata;
  logic [TW:0]   prev_rdata, next_rdata;
  logic [RW-1:0] reg_rdata;
  logic          map_re, link_re, reg_re;

  // Unpacked links of the buffer being freed
  logic          e_hp, e_hn;
  logic [TW-1:0] e_p,  e_n;

  // Result register
  logic                out_valid_q;
  logic [TW+2:0]       alloc_tag_x, map_tag_x;
  logic [RW+REG_W-1:0] buf_reg_x;
  logic [CW+CNT_W-1:0] cnt_x;
  logic                map_pres;
  logic                buf_busy;

  assign ridx   = RW'(reg_q);
  assign tidx   = TW'(tag_q);
  assign reg_ok = (32'(reg_q) < 32'(NUM_REGS));
  assign tag_ok = (32'(tag_q) < 32'(NUM_BUFFERS));

  assign {e_hp, e_p} = prev_rdata;
  assign {e_hn, e_n} = next_rdata;

  // Lowest free buffer
  always_comb begin
    free_idx = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = TW'(i);
      end
    end
  end

  // Status to the sequencer
  assign sts_o.cmd      = cmd_e'(cmd_q);
  assign sts_o.alloc_go = reg_ok && !(&busy_q);
  assign sts_o.free_go  = tag_ok && busy_q[tidx];
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Map table: newest buffer per register
  assign map_re    = ctl_i.alloc_rd || ctl_i.rep_rd;
  assign map_we    = ctl_i.alloc_wr || (ctl_i.free_wr && !e_hn);
  assign map_waddr = ctl_i.alloc_wr ? ridx : reg_rdata;
  assign map_wdata = ctl_i.alloc_wr ? alloc_t_q : e_p;

  // Backward links: the new buffer, or the successor of a freed one
  assign prev_we    = ctl_i.alloc_wr || (ctl_i.free_wr && e_hn);
  assign prev_waddr = ctl_i.alloc_wr ? alloc_t_q : e_n;
  assign prev_wdata = ctl_i.alloc_wr ? {present_q[ridx], map_rdata} : prev_rdata;

  // Forward links: cleared on allocate, set on link, spliced on free
  assign next_we = ctl_i.alloc_wr || (ctl_i.alloc_link && alloc_prev_q)
                   || (ctl_i.free_wr && e_hp);
  always_comb begin
    if (ctl_i.alloc_wr) begin
      next_waddr = alloc_t_q;
      next_wdata = '0;
    end else if (ctl_i.alloc_link) begin
      next_waddr = map_rdata;
      next_wdata = {1'b1, alloc_t_q};
    end else begin
      next_waddr = e_p;
      next_wdata = next_rdata;
    end
  end

  assign link_re   = ctl_i.free_rd;
  assign reg_re    = ctl_i.free_rd || ctl_i.rep_rd;
  assign reg_we    = ctl_i.alloc_wr;
  assign reg_waddr = alloc_t_q;
  assign reg_wdata = ridx;

  grbt_ram #(.WIDTH(TW), .DEPTH(NUM_REGS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (ridx),
    .rdata_o (map_rdata)
  );

  grbt_ram #(.WIDTH(TW + 1), .DEPTH(NUM_BUFFERS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (link_re),
    .raddr_i (tidx),
    .rdata_o (prev_rdata)
  );

  grbt_ram #(.WIDTH(TW + 1), .DEPTH(NUM_BUFFERS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (link_re),
    .raddr_i (tidx),
    .rdata_o (next_rdata)
  );

  grbt_ram #(.WIDTH(RW), .DEPTH(NUM_BUFFERS)) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .re_i    (reg_re),
    .raddr_i (tidx),
    .rdata_o (reg_rdata)
  );

  // Input word and allocation scratch
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      cmd_q     <= cmd_i;
      reg_q     <= reg_num_i;
      tag_q     <= tag_i;
      alloc_t_q <= '0;
    end
    if (ctl_i.alloc_rd) begin
      alloc_t_q <= free_idx;
    end
    if (ctl_i.alloc_wr) begin
      alloc_prev_q <= present_q[ridx];
    end
  end

  // Marks, free counter and allocation result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      ready_q    <= '0;
      present_q  <= '0;
      cnt_q      <= CW'(NUM_BUFFERS);
      alloc_ok_q <= 1'b0;
    end else begin
      if (ctl_i.latch_in) begin
        alloc_ok_q <= 1'b0;
      end
      if (ctl_i.alloc_wr) begin
        busy_q[alloc_t_q]  <= 1'b1;
        ready_q[alloc_t_q] <= 1'b0;
        present_q[ridx]    <= 1'b1;
        cnt_q              <= cnt_q - 1'b1;
        alloc_ok_q         <= 1'b1;
      end
      if (ctl_i.free_wr) begin
        busy_q[tidx]  <= 1'b0;
        ready_q[tidx] <= 1'b0;
        cnt_q         <= cnt_q + 1'b1;
        // newest of its chain: the map falls back to the predecessor
        if (!e_hn) begin
          present_q[reg_rdata] <= e_hp;
        end
      end
      if (ctl_i.mark_rdy && tag_ok) begin
        ready_q[tidx] <= 1'b1;
      end
    end
  end

  // Result word formatting
  assign map_pres    = reg_ok && present_q[ridx];
  assign buf_busy    = tag_ok && busy_q[tidx];
  assign alloc_tag_x = (TW + 3)'(alloc_t_q);
  assign map_tag_x   = (TW + 3)'(map_rdata);
  assign buf_reg_x   = (RW + REG_W)'(reg_rdata);
  assign cnt_x       = (CW + CNT_W)'(cnt_q);

  // Result register and its valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.rep_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rep_ld) begin
      alloc_ok_o     <= alloc_ok_q;
      alloc_tag_o    <= alloc_tag_x[TAG_W-1:0];
      map_present_o  <= map_pres;
      map_tag_o      <= map_pres ? map_tag_x[TAG_W-1:0] : '0;
      buffer_busy_o  <= buf_busy;
      buffer_reg_o   <= buf_busy ? buf_reg_x[REG_W-1:0] : '0;
      buffer_ready_o <= tag_ok && ready_q[tidx];
      free_count_o   <= cnt_x[CNT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/gpr_rename_buffer_table.sv =====
// ----------------------------------------------------------------------------
// gpr_rename_buffer_table
// Rename map for general registers backed by a pool of rename buffers
// chained per register from oldest to newest.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | cmd_i, reg_num_i, tag_i
//  out     | output    | out_valid_o/out_stall_i | alloc_ok_o .. free_count_o
//
//  A query, mark-ready, failed allocation or idle-buffer free runs dispatch,
//  result read and load; a busy-buffer free adds a write, a successful
//  allocation a write and a link state: the map and link tables sit in
//  single-read-port RAMs, so the sequencer gives reads and writes separate cycles.
//  Reset leaves every register unmapped and every buffer free and not ready.
//  A new word is taken while the previous result waits; a stalled output
//  holds the sequencer in its final cycle until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_rename_buffer_table #(
  parameter int unsigned NUM_REGS    = grbt_pkg::NUM_REGS_DEF,
  parameter int unsigned NUM_BUFFERS = grbt_pkg::NUM_BUFFERS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [grbt_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [grbt_pkg::REG_W-1:0]  reg_num_i,
  input  wire logic [grbt_pkg::TAG_W-1:0]  tag_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             alloc_ok_o,
  output logic      [grbt_pkg::TAG_W-1:0]  alloc_tag_o,
  output logic                             map_present_o,
  output logic      [grbt_pkg::TAG_W-1:0]  map_tag_o,
  output logic                             buffer_busy_o,
  output logic      [grbt_pkg::REG_W-1:0]  buffer_reg_o,
  output logic                             buffer_ready_o,
  output logic      [grbt_pkg::CNT_W-1:0]  free_count_o
);

  import grbt_pkg::*;

  ctrl_t   ctl;
  status_t sts;

  // Sequencer
  grbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Tables and result register
  grbt_dp #(
    .NUM_REGS    (NUM_REGS),
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (cmd_i),
    .reg_num_i      (reg_num_i),
    .tag_i          (tag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alloc_ok_o     (alloc_ok_o),
    .alloc_tag_o    (alloc_tag_o),
    .map_present_o  (map_present_o),
    .map_tag_o      (map_tag_o),
    .buffer_busy_o  (buffer_busy_o),
    .buffer_reg_o   (buffer_reg_o),
    .buffer_ready_o (buffer_ready_o),
    .free_count_o   (free_count_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_gpr_rename_buffer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gpr_rename_buffer_table
// Self-checking bench for the general register rename buffer table. A local
// copy of the map and buffer chains predicts every result. The bench drives a
// directed pass over the corner cases and then randomised allocate, free and
// mark traffic, with back-pressure on both channels.
// ----------------------------------------------------------------------------

module tb_gpr_rename_buffer_table;

  import grbt_pkg::*;

  localparam int unsigned NREGS    = NUM_REGS_DEF;
  localparam int unsigned NBUFS    = NUM_BUFFERS_DEF;
  localparam int unsigned WDOG_MAX = 2000;

  // Command codes the block does not define; they act as a query
  localparam logic [CMD_W-1:0] CMD_SPARE0 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE1 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE2 = 3'd7;

  typedef struct packed {
    logic             alloc_ok;
    logic [TAG_W-1:0] alloc_tag;
    logic             map_present;
    logic [TAG_W-1:0] map_tag;
    logic             buffer_busy;
    logic [REG_W-1:0] buffer_reg;
    logic             buffer_ready;
    logic [CNT_W-1:0] free_count;
  } rename_report_t;

  // DUT ports
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [CMD_W-1:0] cmd_i       = CMD_QUERY;
  logic [REG_W-1:0] reg_num_i   = '0;
  logic [TAG_W-1:0] tag_i       = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             alloc_ok_o;
  logic [TAG_W-1:0] alloc_tag_o;
  logic             map_present_o;
  logic [TAG_W-1:0] map_tag_o;
  logic             buffer_busy_o;
  logic [REG_W-1:0] buffer_reg_o;
  logic             buffer_ready_o;
  logic [CNT_W-1:0] free_count_o;

  // Predicted rename state
  logic             mp_vld  [NREGS];
  logic [TAG_W-1:0] mp_buf  [NREGS];
  logic             bf_busy [NBUFS];
  logic [REG_W-1:0] bf_reg  [NBUFS];
  logic             bf_rdy  [NBUFS];
  logic             bf_hp   [NBUFS];
  logic [TAG_W-1:0] bf_prv  [NBUFS];
  logic             bf_hn   [NBUFS];
  logic [TAG_W-1:0] bf_nxt  [NBUFS];
  int unsigned      n_free;

  rename_report_t   rename_report_q[$];
  int unsigned      n_errors     = 0;
  int unsigned      snd_idle_pct = 0;
  int unsigned      rcv_idle_pct = 0;
  int unsigned      hold_left    = 0;
  int unsigned      quiet_cycles = 0;

  gpr_rename_buffer_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .reg_num_i      (reg_num_i),
    .tag_i          (tag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alloc_ok_o     (alloc_ok_o),
    .alloc_tag_o    (alloc_tag_o),
    .map_present_o  (map_present_o),
    .map_tag_o      (map_tag_o),
    .buffer_busy_o  (buffer_busy_o),
    .buffer_reg_o   (buffer_reg_o),
    .buffer_ready_o (buffer_ready_o),
    .free_count_o   (free_count_o)
  );

  always #2 clk_i = ~clk_i;

  // Apply one word to the predicted table and return the report it gives
  function automatic rename_report_t rename_table_step(input logic [CMD_W-1:0] cmd,
                                                       input logic [REG_W-1:0] rnum,
                                                       input logic [TAG_W-1:0] tg);
    rename_report_t res;
    logic [TAG_W-1:0] t;
    bit found;
    res   = '0;
    t     = '0;
    found = 1'b0;
    case (cmd) inside
      CMD_ALLOC: begin
        if (rnum < NREGS) begin
          for (int i = 0; i < NBUFS; i++) begin
            if (!found && !bf_busy[i]) begin
              found = 1'b1;
              t     = TAG_W'(i);
            end
          end
        end
        if (found) begin
          bf_busy[t] = 1'b1;
          bf_reg[t]  = rnum;
          bf_rdy[t]  = 1'b0;
          bf_hn[t]   = 1'b0;
          bf_nxt[t]  = '0;
          bf_hp[t]   = mp_vld[rnum];
          bf_prv[t]  = mp_buf[rnum];
          // hook the new buffer behind the current newest one
          if (bf_hp[t]) begin
            bf_hn[bf_prv[t]]  = 1'b1;
            bf_nxt[bf_prv[t]] = t;
          end
          mp_vld[rnum]  = 1'b1;
          mp_buf[rnum]  = t;
          n_free        = n_free - 1;
          res.alloc_ok  = 1'b1;
          res.alloc_tag = t;
        end
      end
      CMD_FREE_IO, CMD_FREE_RV: begin
        if (tg < NBUFS && bf_busy[tg]) begin
          // unlink from the chain; the map falls back when it was the newest
          if (bf_hn[tg]) begin
            bf_hp[bf_nxt[tg]]  = bf_hp[tg];
            bf_prv[bf_nxt[tg]] = bf_prv[tg];
          end else if (bf_reg[tg] < NREGS) begin
            mp_vld[bf_reg[tg]] = bf_hp[tg];
            mp_buf[bf_reg[tg]] = bf_hp[tg] ? bf_prv[tg] : '0;
          end
          if (bf_hp[tg]) begin
            bf_hn[bf_prv[tg]]  = bf_hn[tg];
            bf_nxt[bf_prv[tg]] = bf_nxt[tg];
          end
          bf_busy[tg] = 1'b0;
          bf_reg[tg]  = '0;
          bf_rdy[tg]  = 1'b0;
          bf_hp[tg]   = 1'b0;
          bf_prv[tg]  = '0;
          bf_hn[tg]   = 1'b0;
          bf_nxt[tg]  = '0;
          n_free      = n_free + 1;
        end
      end
      CMD_MARK: begin
        if (tg < NBUFS) bf_rdy[tg] = 1'b1;
      end
      default: ;
    endcase
    if (rnum < NREGS && mp_vld[rnum]) begin
      res.map_present = 1'b1;
      res.map_tag     = mp_buf[rnum];
    end
    if (tg < NBUFS) begin
      res.buffer_busy  = bf_busy[tg];
      res.buffer_reg   = bf_busy[tg] ? bf_reg[tg] : '0;
      res.buffer_ready = bf_rdy[tg];
    end
    res.free_count = CNT_W'(n_free);
    return res;
  endfunction

  // Oldest or newest buffer of some chain, else any tag
  function automatic logic [TAG_W-1:0] chain_end_tag(input bit oldest);
    logic [TAG_W-1:0] cand[$];
    for (int i = 0; i < NBUFS; i++) begin
      if (bf_busy[i] && (oldest ? !bf_hp[i] : !bf_hn[i])) cand.push_back(TAG_W'(i));
    end
    if (cand.size() == 0) return TAG_W'($urandom_range(NBUFS - 1));
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  // Offer one word, wait for it to be taken and queue its predicted report
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [REG_W-1:0] rnum,
                           input logic [TAG_W-1:0] tg);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    reg_num_i  <= rnum;
    tag_i      <= tg;
    do @(posedge clk_i); while (in_stall_o);
    rename_report_q.push_back(rename_table_step(cmd, rnum, tg));
  endtask

  // Drop valid and wait until every queued report has been seen
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (rename_report_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Compare each report word against the oldest prediction
  always @(posedge clk_i) begin
    rename_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rename_report_q.size() == 0) begin
        n_errors++;
        $display("%0t: report word with nothing outstanding", $time);
      end else begin
        want = rename_report_q.pop_front();
        check_field("alloc_ok",     32'(want.alloc_ok),     32'(alloc_ok_o));
        check_field("alloc_tag",    32'(want.alloc_tag),    32'(alloc_tag_o));
        check_field("map_present",  32'(want.map_present),  32'(map_present_o));
        check_field("map_tag",      32'(want.map_tag),      32'(map_tag_o));
        check_field("buffer_busy",  32'(want.buffer_busy),  32'(buffer_busy_o));
        check_field("buffer_reg",   32'(want.buffer_reg),   32'(buffer_reg_o));
        check_field("buffer_ready", 32'(want.buffer_ready), 32'(buffer_ready_o));
        check_field("free_count",   32'(want.free_count),   32'(free_count_o));
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WDOG_MAX) begin
      $display("%0t: no progress for %0d cycles", $time, WDOG_MAX);
      $display("status: fail");
      $finish;
    end
  end

  // Corner cases: idle buffers, full pool, chain ends and middles, spare codes
  task automatic test_directed_cases();
    send_word(CMD_QUERY,   5'd0,  3'd0);
    send_word(CMD_MARK,    5'd31, 3'd7);   // ready bit on an idle buffer
    send_word(CMD_FREE_IO, 5'd31, 3'd7);   // idle buffer, no change
    send_word(CMD_FREE_RV, 5'd0,  3'd7);
    send_word(CMD_ALLOC,   5'd31, 3'd0);
    send_word(CMD_ALLOC,   5'd31, 3'd1);
    send_word(CMD_ALLOC,   5'd31, 3'd2);
    send_word(CMD_ALLOC,   5'd0,  3'd3);
    send_word(CMD_ALLOC,   5'd0,  3'd4);
    send_word(CMD_ALLOC,   5'd5,  3'd5);
    send_word(CMD_ALLOC,   5'd31, 3'd6);
    send_word(CMD_ALLOC,   5'd17, 3'd7);   // clears the earlier ready bit
    send_word(CMD_ALLOC,   5'd9,  3'd0);   // pool exhausted
    send_word(CMD_MARK,    5'd31, 3'd1);
    send_word(CMD_FREE_IO, 5'd31, 3'd0);   // oldest of its chain
    send_word(CMD_FREE_RV, 5'd31, 3'd2);   // middle of the chain
    send_word(CMD_FREE_RV, 5'd31, 3'd6);   // newest, map falls back
    send_word(CMD_FREE_IO, 5'd0,  3'd4);   // in-order free hitting the newest
    send_word(CMD_SPARE0,  5'd31, 3'd1);
    send_word(CMD_SPARE1,  5'd0,  3'd3);
    send_word(CMD_SPARE2,  5'd17, 3'd7);
    send_word(CMD_ALLOC,   5'd31, 3'd0);
    send_word(CMD_FREE_RV, 5'd31, 3'd0);
    send_word(CMD_FREE_IO, 5'd31, 3'd1);   // chain now empty
    send_word(CMD_QUERY,   5'd31, 3'd1);
  endtask

  // Weighted random traffic; most words work a few registers into long chains
  task automatic test_random_traffic(input int unsigned n_words, input int unsigned snd_pct,
                                     input int unsigned rcv_pct);
    int unsigned r;
    logic [CMD_W-1:0] cmd;
    logic [REG_W-1:0] rnum;
    logic [TAG_W-1:0] tg;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (n_words) begin
      r    = $urandom_range(99);
      rnum = ($urandom_range(9) < 7) ? REG_W'($urandom_range(3))
                                     : REG_W'($urandom_range(NREGS - 1));
      tg   = TAG_W'($urandom_range(NBUFS - 1));
      if (r < 30) begin
        cmd = CMD_ALLOC;
      end else if (r < 48) begin
        cmd = CMD_FREE_IO;
        if ($urandom_range(3) != 0) tg = chain_end_tag(1'b1);
      end else if (r < 66) begin
        cmd = CMD_FREE_RV;
        if ($urandom_range(3) != 0) tg = chain_end_tag(1'b0);
      end else if (r < 80) begin
        cmd = CMD_MARK;
      end else if (r < 92) begin
        cmd = CMD_QUERY;
      end else begin
        cmd = CMD_W'($urandom_range(CMD_SPARE2, CMD_SPARE0));
      end
      send_word(cmd, rnum, tg);
    end
  endtask

  // Long receiver hold-off while words keep coming, so the input backs up
  task automatic test_output_hold_off();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_left    = 300;
    test_random_traffic(20, 0, 0);
  endtask

  // Sender waits for every report before going on
  task automatic test_drain_pause();
    wait_drained();
    test_random_traffic(12, 15, 15);
  endtask

  initial begin
    for (int i = 0; i < NREGS; i++) begin
      mp_vld[i] = 1'b0;
      mp_buf[i] = '0;
    end
    for (int i = 0; i < NBUFS; i++) begin
      bf_busy[i] = 1'b0;
      bf_reg[i]  = '0;
      bf_rdy[i]  = 1'b0;
      bf_hp[i]   = 1'b0;
      bf_prv[i]  = '0;
      bf_hn[i]   = 1'b0;
      bf_nxt[i]  = '0;
    end
    n_free = NBUFS;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_traffic(280, 15, 49);
    test_random_traffic(280, 49, 15);
    test_random_traffic(280, 0, 0);
    test_output_hold_off();
    test_drain_pause();

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
